FILE: rtl/core/npt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npt_pkg
// Shared types, command codes and entry constants of the nested page table
// builder.
// ----------------------------------------------------------------------------
package npt_pkg;

   // command codes
   localparam logic [2:0] CMD_MAP4K     = 3'd0;
   localparam logic [2:0] CMD_MAP2M     = 3'd1;
   localparam logic [2:0] CMD_PROBE     = 3'd2;
   localparam logic [2:0] CMD_SEARCH    = 3'd3;
   localparam logic [2:0] CMD_CLEAR_OVL = 3'd4;
   localparam logic [2:0] CMD_CLEAR_ALL = 3'd5;

   // status codes
   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_RO_WRITE = 2'd1;
   localparam logic [1:0] ST_LARGE    = 2'd2;
   localparam logic [1:0] ST_OVERLAP  = 2'd3;

   // configuration register indexes
   localparam logic CSR_POOL_BASE = 1'b0;
   localparam logic CSR_ADDR_MASK = 1'b1;

   localparam logic [51:0] ADDR_MASK_RESET = 52'hFFFFFFFFFF000;

   // entry bits
   localparam int unsigned BIT_READ  = 0;
   localparam int unsigned BIT_WRITE = 1;
   localparam int unsigned BIT_LARGE = 7;
   localparam logic [11:0] ENT_PTR_ATTR = 12'h007;
   localparam logic [51:0] SPAN_4K = 52'h0000000000FFF;
   localparam logic [51:0] SPAN_2M = 52'h00000001FFFFF;

   localparam int unsigned ENT_IDX_W = 9;
   localparam int unsigned LVL_W     = 3;
   localparam logic [LVL_W-1:0] LVL_NONE = 3'd4;
   localparam logic [LVL_W-1:0] LVL_ROOT = 3'd3;

   typedef enum logic [3:0] {
      S_CLR,
      S_IDLE,
      S_WSTART,
      S_WALK_RD,
      S_WALK_CHK,
      S_POST,
      S_FILL_CHK,
      S_FILL_START,
      S_FILL_PTR,
      S_ZERO,
      S_LEAF,
      S_SCAN,
      S_DONE
   } state_type;

   // table index of a guest address at one walk level
   function automatic logic [ENT_IDX_W-1:0] idx_at(input logic [47:0] ga,
                                                   input logic [1:0] lvl);
      logic [ENT_IDX_W-1:0] r;
      case (lvl)
         2'd0:    r = ga[20:12];
         2'd1:    r = ga[29:21];
         2'd2:    r = ga[38:30];
         default: r = ga[47:39];
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/npt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module npt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 512
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire  [$clog2(DEPTH)-1:0] wr_addr,
   input  wire  [WIDTH-1:0]         wr_data,
   input  wire  [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

FILE: rtl/core/nested_page_table_builder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nested_page_table_builder
// Builds a four-level nested page table in a root RAM and a pool RAM.
// ----------------------------------------------------------------------------
// Steps: a probe reads one entry per table level walked, from the cached resume level;
//   a map writes a pointer and zeroes a 512-entry table per new one; overflow adds a root clear.
// Clear all runs the root clearing pass; overlap commands scan each pool table in use.
// One command at a time; next start is taken in the response cycle; no output stall.
// Reset: root clearing pass, busy stays high until it ends.
module nested_page_table_builder
   import npt_pkg::*;
#(
   parameter int POOL_TABLES = 64
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  wire  [2:0]  req_cmd,
   input  wire  [47:0] req_guest_addr,
   input  wire  [39:0] req_host_frame,
   input  wire  [2:0]  req_mem_type,
   input  wire         req_read_only,
   input  wire         req_is_write,
   input  wire  [51:0] req_range_start,
   input  wire  [51:0] req_range_end,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_walk_depth,
   output logic        rsp_pool_cleared,
   output logic [6:0]  rsp_tables_in_use,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire         csr_index,
   input  wire  [51:0] csr_wdata
);

   localparam int PTW = $clog2(POOL_TABLES);
   localparam int PAW = PTW + ENT_IDX_W;
   localparam int PCW = $clog2(POOL_TABLES + 1);
   localparam int ROOT_DEPTH = 1 << ENT_IDX_W;

   // configuration
   logic [39:0] base_ff;
   logic [51:0] mask_ff;

   // latched request
   logic [2:0]  cmd_ff;
   logic [47:0] ga_ff;
   logic [39:0] hf_ff;
   logic [2:0]  mt_ff;
   logic        ro_ff, wr_ff;
   logic [51:0] rs_ff, re_ff;

   // control
   state_type state_ff, state_in, ret_ff, ret_in;
   logic [ENT_IDX_W-1:0] ctr_ff, ctr_in;
   logic [LVL_W-1:0] cdepth_ff, cdepth_in;
   logic [47:0] caddr_ff, caddr_in;
   logic [PAW-1:0] cpos_ff [4];
   logic [PAW-1:0] cpos_in [4];
   logic [LVL_W-1:0] lvl_ff, lvl_in;
   logic [PCW-1:0] pcount_ff, pcount_in;
   logic [1:0] fl_ff, fl_in;
   logic [PAW-1:0] fpos_ff, fpos_in;
   logic target_ff, target_in;
   logic [1:0] status_ff, status_in;
   logic [LVL_W-1:0] dout_ff, dout_in;
   logic cleared_ff, cleared_in;
   logic hit_ff, hit_in;
   logic iss_ff, iss_in, sv_ff, sv_in;
   logic [PAW-1:0] saddr_ff, saddr_in, sa_ff, sa_in;

   // result registers
   logic rvalid_ff;
   logic [1:0] rstat_ff;
   logic [2:0] rdepth_ff;
   logic rclr_ff;
   logic [6:0] rtab_ff;

   // RAM ports
   logic root_we;
   logic [ENT_IDX_W-1:0] root_wa, root_ra;
   logic [63:0] root_wd, root_rd;
   logic pool_we;
   logic [PAW-1:0] pool_wa, pool_ra;
   logic [63:0] pool_wd, pool_rd;

   npt_ram #(.WIDTH(64), .DEPTH(ROOT_DEPTH)) u_root (
      .clock   (clock),
      .wr_en   (root_we),
      .wr_addr (root_wa),
      .wr_data (root_wd),
      .rd_addr (root_ra),
      .rd_data (root_rd)
   );

   npt_ram #(.WIDTH(64), .DEPTH(POOL_TABLES * ROOT_DEPTH)) u_pool (
      .clock   (clock),
      .wr_en   (pool_we),
      .wr_addr (pool_wa),
      .wr_data (pool_wd),
      .rd_addr (pool_ra),
      .rd_data (pool_rd)
   );

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   assign rsp_valid         = rvalid_ff;
   assign rsp_status        = rstat_ff;
   assign rsp_walk_depth    = rdepth_ff;
   assign rsp_pool_cleared  = rclr_ff;
   assign rsp_tables_in_use = rtab_ff;

   // walk helpers
   logic [LVL_W-1:0] wstart_lvl;
   logic [63:0] wentry;
   logic [39:0] wframe, woff;
   logic        wok;
   logic [PTW-1:0] tnext;
   logic [39:0] tframe;
   logic [PCW:0] need_sum;
   logic [PTW-1:0] last_tab;
   logic [51:0] sa_lo, sa_hi;
   logic shit;

   always_comb begin
      // resume level: first shared level at or above the cached depth
      logic [4:0] match;
      logic [LVL_W-1:0] st;
      for (int l = 0; l < 4; l++) begin
         match[l] = (((ga_ff ^ caddr_ff) >> (12 + 9 * l)) == 48'd0);
      end
      match[4] = 1'b1;
      st = (cdepth_ff > LVL_NONE) ? LVL_NONE : cdepth_ff;
      wstart_lvl = LVL_NONE;
      for (int l = 4; l >= 0; l--) begin
         if (match[l] && (LVL_W'(l) >= st)) begin
            wstart_lvl = LVL_W'(l);
         end
      end
   end

   // entry check during the walk
   assign wentry = (lvl_ff == LVL_ROOT) ? root_rd : pool_rd;
   assign wframe = wentry[51:12];
   assign woff   = wframe - base_ff;
   assign wok    = wentry[BIT_READ] && !wentry[BIT_LARGE] && (wframe >= base_ff)
                   && (woff < 40'(POOL_TABLES));

   // next free pool table
   assign tnext  = pcount_ff[PTW-1:0];
   assign tframe = base_ff + 40'(tnext);
   assign need_sum = (PCW+1)'(pcount_ff) + (PCW+1)'(cdepth_ff)
                     - (PCW+1)'(target_ff);
   assign last_tab = PTW'(pcount_ff - PCW'(1));

   // overlap test on the entry read last cycle
   always_comb begin
      sa_lo = pool_rd[51:0] & mask_ff;
      sa_hi = sa_lo | SPAN_4K;
      if (pool_rd[BIT_LARGE]) begin
         sa_lo = sa_lo & ~SPAN_2M;
         sa_hi = sa_hi | SPAN_2M;
      end
   end
   assign shit = pool_rd[BIT_READ] && (rs_ff <= sa_hi) && (sa_lo <= re_ff);

   // state register and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLR;
         ret_ff    <= S_IDLE;
         ctr_ff    <= '0;
         cdepth_ff <= LVL_NONE;
         caddr_ff  <= '0;
         for (int i = 0; i < 4; i++) cpos_ff[i] <= '0;
         pcount_ff <= '0;
         iss_ff    <= 1'b0;
         sv_ff     <= 1'b0;
         hit_ff    <= 1'b0;
         rvalid_ff <= 1'b0;
         base_ff   <= '0;
         mask_ff   <= ADDR_MASK_RESET;
      end else begin
         state_ff  <= state_in;
         ret_ff    <= ret_in;
         ctr_ff    <= ctr_in;
         cdepth_ff <= cdepth_in;
         caddr_ff  <= caddr_in;
         for (int i = 0; i < 4; i++) cpos_ff[i] <= cpos_in[i];
         pcount_ff <= pcount_in;
         iss_ff    <= iss_in;
         sv_ff     <= sv_in;
         hit_ff    <= hit_in;
         rvalid_ff <= (state_ff == S_DONE);
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_POOL_BASE: base_ff <= csr_wdata[39:0];
               CSR_ADDR_MASK: mask_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      lvl_ff     <= lvl_in;
      fl_ff      <= fl_in;
      fpos_ff    <= fpos_in;
      target_ff  <= target_in;
      status_ff  <= status_in;
      dout_ff    <= dout_in;
      cleared_ff <= cleared_in;
      saddr_ff   <= saddr_in;
      sa_ff      <= sa_in;
      if (start && !busy) begin
         cmd_ff <= req_cmd;
         ga_ff  <= req_guest_addr;
         hf_ff  <= req_host_frame;
         mt_ff  <= req_mem_type;
         ro_ff  <= req_read_only;
         wr_ff  <= req_is_write;
         rs_ff  <= req_range_start;
         re_ff  <= req_range_end;
      end
      if (state_ff == S_DONE) begin
         rstat_ff  <= status_ff;
         rdepth_ff <= (cmd_ff == CMD_MAP4K || cmd_ff == CMD_MAP2M || cmd_ff == CMD_PROBE)
                      ? dout_ff : cdepth_ff;
         rclr_ff   <= cleared_ff;
         rtab_ff   <= 7'(pcount_ff);
      end
   end

   // next state and RAM control
   always_comb begin
      logic [2:0]  leaf_attr;
      logic [63:0] leaf;
      state_in   = state_ff;
      ret_in     = ret_ff;
      ctr_in     = ctr_ff;
      cdepth_in  = cdepth_ff;
      caddr_in   = caddr_ff;
      for (int i = 0; i < 4; i++) cpos_in[i] = cpos_ff[i];
      pcount_in  = pcount_ff;
      lvl_in     = lvl_ff;
      fl_in      = fl_ff;
      fpos_in    = fpos_ff;
      target_in  = target_ff;
      status_in  = status_ff;
      dout_in    = dout_ff;
      cleared_in = cleared_ff;
      hit_in     = hit_ff;
      iss_in     = 1'b0;
      sv_in      = 1'b0;
      saddr_in   = saddr_ff;
      sa_in      = sa_ff;
      root_we    = 1'b0;
      root_wa    = ctr_ff;
      root_wd    = '0;
      root_ra    = cpos_ff[3][ENT_IDX_W-1:0];
      pool_we    = 1'b0;
      pool_wa    = {tnext, ctr_ff};
      pool_wd    = '0;
      pool_ra    = cpos_ff[lvl_ff[1:0]];

      // leaf entry: 2M leaves drop the low frame bits and set the large bit
      leaf_attr = ro_ff ? 3'b101 : 3'b111;
      if (cmd_ff == CMD_MAP2M) begin
         leaf = {12'd0, hf_ff[39:9], 9'd0, 4'h0, 2'b10, mt_ff, 3'b111};
      end else begin
         leaf = {12'd0, hf_ff, 6'd0, mt_ff, leaf_attr};
      end

      case (state_ff)
         // root clearing pass
         S_CLR: begin
            root_we = 1'b1;
            root_wa = ctr_ff;
            ctr_in  = ctr_ff + 1'b1;
            if (ctr_ff == '1) begin
               state_in = ret_ff;
            end
         end

         S_IDLE: begin
            status_in  = ST_DONE;
            cleared_in = 1'b0;
            hit_in     = 1'b0;
            if (start) begin
               case (req_cmd)
                  CMD_MAP4K, CMD_MAP2M, CMD_PROBE: state_in = S_WSTART;
                  CMD_SEARCH, CMD_CLEAR_OVL: begin
                     saddr_in = '0;
                     iss_in   = (pcount_ff != '0);
                     state_in = S_SCAN;
                  end
                  CMD_CLEAR_ALL: begin
                     pcount_in  = '0;
                     cdepth_in  = LVL_NONE;
                     cleared_in = 1'b1;
                     ctr_in     = '0;
                     ret_in     = S_DONE;
                     state_in   = S_CLR;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end

         // resume point from the walk cache
         S_WSTART: begin
            caddr_in = ga_ff;
            if (wstart_lvl >= LVL_NONE) begin
               lvl_in     = LVL_ROOT;
               cpos_in[3] = PAW'(idx_at(ga_ff, 2'd3));
            end else begin
               lvl_in = wstart_lvl;
            end
            state_in = S_WALK_RD;
         end

         S_WALK_RD: begin
            if (lvl_ff == '0) begin
               cdepth_in = '0;
               state_in  = S_POST;
            end else begin
               state_in = S_WALK_CHK;
            end
         end

         S_WALK_CHK: begin
            if (wok) begin
               lvl_in = lvl_ff - 1'b1;
               cpos_in[lvl_in[1:0]] = {woff[PTW-1:0], idx_at(ga_ff, lvl_in[1:0])};
               state_in = S_WALK_RD;
            end else begin
               cdepth_in = lvl_ff;
               state_in  = S_POST;
            end
         end

         S_POST: begin
            dout_in = lvl_ff;
            case (cmd_ff)
               CMD_MAP4K: begin
                  target_in = 1'b0;
                  if (ro_ff && wr_ff) begin
                     status_in = ST_RO_WRITE;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_FILL_CHK;
                  end
               end
               CMD_MAP2M: begin
                  target_in = 1'b1;
                  if (lvl_ff == '0) begin
                     status_in = ST_LARGE;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_FILL_CHK;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end

         // pool overflow: clear the root and restart from it
         S_FILL_CHK: begin
            if (need_sum > (PCW+1)'(POOL_TABLES)) begin
               pcount_in  = '0;
               cdepth_in  = LVL_ROOT;
               cpos_in[3] = PAW'(idx_at(ga_ff, 2'd3));
               cleared_in = 1'b1;
               ctr_in     = '0;
               ret_in     = S_FILL_START;
               state_in   = S_CLR;
            end else begin
               state_in = S_FILL_START;
            end
         end

         S_FILL_START: begin
            fl_in   = cdepth_ff[1:0];
            fpos_in = cpos_ff[cdepth_ff[1:0]];
            state_in = (cdepth_ff[1:0] > {1'b0, target_ff}) ? S_FILL_PTR : S_LEAF;
         end

         // pointer to the next pool table
         S_FILL_PTR: begin
            if (fl_ff == 2'd3) begin
               root_we = 1'b1;
               root_wa = fpos_ff[ENT_IDX_W-1:0];
               root_wd = {12'd0, tframe, ENT_PTR_ATTR};
            end else begin
               pool_we = 1'b1;
               pool_wa = fpos_ff;
               pool_wd = {12'd0, tframe, ENT_PTR_ATTR};
            end
            ctr_in   = '0;
            state_in = S_ZERO;
         end

         // zero the new table
         S_ZERO: begin
            pool_we = 1'b1;
            pool_wa = {tnext, ctr_ff};
            pool_wd = '0;
            ctr_in  = ctr_ff + 1'b1;
            if (ctr_ff == '1) begin
               pcount_in = pcount_ff + 1'b1;
               fl_in     = fl_ff - 1'b1;
               fpos_in   = {tnext, idx_at(ga_ff, fl_in)};
               state_in  = (fl_in > {1'b0, target_ff}) ? S_FILL_PTR : S_LEAF;
            end
         end

         S_LEAF: begin
            pool_we  = 1'b1;
            pool_wa  = fpos_ff;
            pool_wd  = leaf;
            state_in = S_DONE;
         end

         // pool scan, one read issued and one entry checked per cycle
         S_SCAN: begin
            pool_ra = saddr_ff;
            if (iss_ff) begin
               sv_in = 1'b1;
               sa_in = saddr_ff;
               if (saddr_ff == {last_tab, {ENT_IDX_W{1'b1}}}) begin
                  iss_in = 1'b0;
               end else begin
                  iss_in   = 1'b1;
                  saddr_in = saddr_ff + 1'b1;
               end
            end
            if (sv_ff && shit) begin
               hit_in = 1'b1;
               if (cmd_ff == CMD_CLEAR_OVL) begin
                  pool_we = 1'b1;
                  pool_wa = sa_ff;
                  pool_wd = '0;
               end else begin
                  iss_in    = 1'b0;
                  sv_in     = 1'b0;
                  status_in = ST_OVERLAP;
                  state_in  = S_DONE;
               end
            end
            if (!iss_ff && !sv_ff) begin
               status_in = hit_ff ? ST_OVERLAP : ST_DONE;
               state_in  = S_DONE;
            end
         end

         S_DONE: begin
            state_in = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase
   end

endmodule
`default_nettype wire

FILE: verif/nested_page_table_builder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nested_page_table_builder_checker
// Watches the command, response and CSR channels of the page table builder,
// keeps its own copy of the root table, table pool and walk cache, and
// compares every response field with the predicted one.
// ----------------------------------------------------------------------------
module nested_page_table_builder_checker
   import npt_pkg::*;
#(
   parameter int POOL_TABLES = 64
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   input  wire         busy,
   input  wire  [2:0]  req_cmd,
   input  wire  [47:0] req_guest_addr,
   input  wire  [39:0] req_host_frame,
   input  wire  [2:0]  req_mem_type,
   input  wire         req_read_only,
   input  wire         req_is_write,
   input  wire  [51:0] req_range_start,
   input  wire  [51:0] req_range_end,
   input  wire         rsp_valid,
   input  wire  [1:0]  rsp_status,
   input  wire  [2:0]  rsp_walk_depth,
   input  wire         rsp_pool_cleared,
   input  wire  [6:0]  rsp_tables_in_use,
   input  wire         csr_valid,
   input  wire         csr_ready,
   input  wire         csr_index,
   input  wire  [51:0] csr_wdata,
   output int          errors,
   output int          outstanding
);

   localparam int unsigned ENTRIES  = 512;
   localparam int unsigned LEVELS   = 4;
   localparam int unsigned POOL_ENT = POOL_TABLES * ENTRIES;
   localparam logic [63:0] FRAME_M  = 64'hFF_FFFF_FFFF;

   typedef struct packed {
      logic [1:0] status;
      logic [2:0] depth;
      logic       cleared;
      logic [6:0] in_use;
   } npt_rsp_type;

   // shadow copy of the table memories and walk cache
   bit [63:0]   root_tbl [ENTRIES];
   bit [63:0]   pool_mem [POOL_ENT];
   int unsigned tables_used;
   int unsigned walk_lvl;
   bit [63:0]   walk_addr;
   int unsigned walk_pos [LEVELS];
   bit [39:0]   base_frame;
   bit [51:0]   addr_mask;

   npt_rsp_type rsp_due_q [$];

   function automatic bit [63:0] entry_get(int unsigned lvl, int unsigned pos);
      if (lvl >= LEVELS - 1) return root_tbl[pos % ENTRIES];
      return pool_mem[pos % POOL_ENT];
   endfunction

   function automatic void entry_put(int unsigned lvl, int unsigned pos, bit [63:0] v);
      if (lvl >= LEVELS - 1) root_tbl[pos % ENTRIES] = v;
      else pool_mem[pos % POOL_ENT] = v;
   endfunction

   function automatic int unsigned tbl_index(bit [63:0] ga, int unsigned lvl);
      return int'((ga >> (9 * lvl + 12)) & 64'h1FF);
   endfunction

   // walk from the deepest cached level shared with the previous address
   function automatic void resolve_walk(bit [63:0] ga);
      bit [63:0]   m;
      bit [63:0]   e;
      bit [63:0]   fr;
      bit [63:0]   off;
      int unsigned l;
      m = 64'hFFFF_FFFF_FFFF_F000;
      l = walk_lvl;
      if (l > LEVELS) l = LEVELS;
      if (l > 0) m = m << (9 * l);
      while (l < LEVELS && (ga & m) != (walk_addr & m)) begin
         l++;
         m = m << 9;
      end
      walk_addr = ga;
      if (l == 0) begin
         walk_lvl = 0;
         return;
      end
      if (l >= LEVELS) begin
         l = LEVELS - 1;
         walk_pos[l] = tbl_index(ga, l);
      end
      while (l > 0) begin
         e = entry_get(l, walk_pos[l]);
         if (!e[BIT_READ] || e[BIT_LARGE]) break;
         fr  = (e >> 12) & FRAME_M;
         off = (fr - {24'd0, base_frame}) & FRAME_M;
         if (fr < {24'd0, base_frame} || off >= POOL_TABLES) break;
         l--;
         walk_pos[l] = int'(off) * ENTRIES + tbl_index(ga, l);
      end
      walk_lvl = l;
   endfunction

   // allocate missing tables down to the target level, clear root on overflow
   function automatic int unsigned alloc_tables(bit [63:0] ga, int unsigned target,
                                                inout bit cleared);
      int unsigned l;
      int unsigned pos;
      int unsigned t;
      bit [63:0]   fr;
      if (tables_used + walk_lvl - target > POOL_TABLES) begin
         foreach (root_tbl[i]) root_tbl[i] = '0;
         tables_used = 0;
         walk_lvl = LEVELS - 1;
         walk_pos[LEVELS-1] = tbl_index(ga, LEVELS - 1);
         cleared = 1'b1;
      end
      l = walk_lvl;
      pos = walk_pos[l % LEVELS];
      for (; l > target; l--) begin
         t  = tables_used % POOL_TABLES;
         fr = ({24'd0, base_frame} + t) & FRAME_M;
         entry_put(l, pos, (fr << 12) | 64'h7);
         for (int j = 0; j < ENTRIES; j++) pool_mem[t * ENTRIES + j] = '0;
         tables_used++;
         pos = t * ENTRIES + tbl_index(ga, l - 1);
      end
      return pos;
   endfunction

   // look for present pool entries whose host span meets [lo, hi]
   function automatic bit overlap_scan(bit [63:0] lo, bit [63:0] hi, bit wipe);
      int unsigned n;
      bit          hit;
      bit [63:0]   e;
      bit [63:0]   a;
      bit [63:0]   b;
      hit = 1'b0;
      n = (tables_used > POOL_TABLES) ? POOL_TABLES : tables_used;
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j < ENTRIES; j++) begin
            e = pool_mem[i * ENTRIES + j];
            if (!e[BIT_READ]) continue;
            a = e & {12'd0, addr_mask};
            b = a | 64'hFFF;
            if (e[BIT_LARGE]) begin
               a = a & ~64'h1F_FFFF;
               b = b | 64'h1F_FFFF;
            end
            if (lo <= b && a <= hi) begin
               hit = 1'b1;
               if (!wipe) return 1'b1;
               pool_mem[i * ENTRIES + j] = '0;
            end
         end
      end
      return hit;
   endfunction

   // predicted response of one command
   function automatic npt_rsp_type predict_cmd();
      npt_rsp_type r;
      bit          cleared;
      bit [63:0]   ga;
      bit [63:0]   attr;
      int unsigned pos;
      cleared = 1'b0;
      ga = {16'd0, req_guest_addr};
      r.status = ST_DONE;
      case (req_cmd)
         CMD_MAP4K: begin
            resolve_walk(ga);
            r.depth = walk_lvl[2:0];
            if (req_read_only && req_is_write) begin
               r.status = ST_RO_WRITE;
            end else begin
               attr = {58'd0, req_mem_type, 3'b111};
               if (req_read_only) attr[BIT_WRITE] = 1'b0;
               pos = alloc_tables(ga, 0, cleared);
               entry_put(0, pos, ({24'd0, req_host_frame} << 12) | attr);
            end
         end
         CMD_MAP2M: begin
            resolve_walk(ga);
            r.depth = walk_lvl[2:0];
            if (walk_lvl == 0) begin
               r.status = ST_LARGE;
            end else begin
               attr = {56'd0, 1'b1, 1'b0, req_mem_type, 3'b111};
               pos = alloc_tables(ga, 1, cleared);
               entry_put(1, pos, ({24'd0, req_host_frame[39:9], 9'd0} << 12) | attr);
            end
         end
         CMD_PROBE: begin
            resolve_walk(ga);
            r.depth = walk_lvl[2:0];
         end
         CMD_SEARCH, CMD_CLEAR_OVL: begin
            if (overlap_scan({12'd0, req_range_start}, {12'd0, req_range_end},
                             req_cmd == CMD_CLEAR_OVL))
               r.status = ST_OVERLAP;
            r.depth = walk_lvl[2:0];
         end
         CMD_CLEAR_ALL: begin
            foreach (root_tbl[i]) root_tbl[i] = '0;
            tables_used = 0;
            walk_lvl = LEVELS;
            cleared = 1'b1;
            r.depth = walk_lvl[2:0];
         end
         default: begin
            r.depth = walk_lvl[2:0];
         end
      endcase
      r.cleared = cleared;
      r.in_use = tables_used[6:0];
      return r;
   endfunction

   // sample channels at the rising edge
   always @(posedge clock) begin
      npt_rsp_type want;
      if (reset) begin
         foreach (root_tbl[i]) root_tbl[i] = '0;
         tables_used = 0;
         walk_lvl = LEVELS;
         walk_addr = '0;
         foreach (walk_pos[i]) walk_pos[i] = 0;
         base_frame = '0;
         addr_mask = ADDR_MASK_RESET;
         rsp_due_q.delete();
         errors = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_POOL_BASE) base_frame = csr_wdata[39:0];
            else addr_mask = csr_wdata;
         end
         if (start && !busy) rsp_due_q.push_back(predict_cmd());
         if (rsp_valid) begin
            if (rsp_due_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%t: response with no command outstanding", $realtime);
            end else begin
               want = rsp_due_q.pop_front();
               if (want.status !== rsp_status || want.depth !== rsp_walk_depth ||
                   want.cleared !== rsp_pool_cleared || want.in_use !== rsp_tables_in_use)
               begin
                  errors++;
                  if (errors <= 10)
                     $display("%t: mismatch exp/act st %0d/%0d dep %0d/%0d clr %0d/%0d use %0d/%0d",
                              $realtime, want.status, rsp_status, want.depth, rsp_walk_depth,
                              want.cleared, rsp_pool_cleared, want.in_use, rsp_tables_in_use);
               end
            end
         end
      end
      outstanding = rsp_due_q.size();
   end

endmodule

FILE: verif/nested_page_table_builder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nested_page_table_builder_tb
// Drives directed and random page table commands with random gaps through
// several pool base and address mask settings; the checker predicts and
// compares every response.
// ----------------------------------------------------------------------------
module nested_page_table_builder_tb
   import npt_pkg::*;
();

   localparam int IDLE_LIMIT = 200000;
   localparam int PHASES     = 6;
   localparam int PHASE_CMDS = 310;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_cmd;
   logic [47:0] req_guest_addr;
   logic [39:0] req_host_frame;
   logic [2:0]  req_mem_type;
   logic        req_read_only;
   logic        req_is_write;
   logic [51:0] req_range_start;
   logic [51:0] req_range_end;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [2:0]  rsp_walk_depth;
   logic        rsp_pool_cleared;
   logic [6:0]  rsp_tables_in_use;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [51:0] csr_wdata;
   int          errors;
   int          outstanding;
   int          idle_cycles = 0;
   int          cmd_count = 0;
   int          clear_count = 0;
   bit [47:0]   region [8];
   bit [39:0]   last_frame;

   nested_page_table_builder dut (.*);
   nested_page_table_builder_checker chk (.*);

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // watchdog on cycles with no transaction, plus run statistics
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (!reset && start && !busy) cmd_count <= cmd_count + 1;
      if (!reset && rsp_valid && rsp_pool_cleared) clear_count <= clear_count + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[nested_page_table_builder] ERROR");
         $finish;
      end
   end

   // one command; called just after a falling edge, returns after the one that follows its acceptance
   task automatic send_cmd(logic [2:0] cmd, logic [47:0] ga, logic [39:0] hf,
                           logic [2:0] mt, logic ro, logic wr,
                           logic [51:0] rs, logic [51:0] re, int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_cmd <= cmd;
      req_guest_addr <= ga;
      req_host_frame <= hf;
      req_mem_type <= mt;
      req_read_only <= ro;
      req_is_write <= wr;
      req_range_start <= rs;
      req_range_end <= re;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // stop sending until every response is back, then let the block settle
   task automatic drain();
      start <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic csr_write(logic idx, logic [51:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // random command, mostly near a few guest regions so walks reuse tables
   task automatic send_random(int gap);
      int          pick;
      logic [2:0]  cmd;
      logic [47:0] ga;
      logic [39:0] hf;
      logic [51:0] rs;
      logic [51:0] re;
      pick = $urandom_range(0, 99);
      if (pick < 42) cmd = CMD_MAP4K;
      else if (pick < 58) cmd = CMD_MAP2M;
      else if (pick < 88) cmd = CMD_PROBE;
      else if (pick < 90) cmd = CMD_SEARCH;
      else if (pick < 92) cmd = CMD_CLEAR_OVL;
      else if (pick < 95) cmd = CMD_CLEAR_ALL;
      else cmd = 3'($urandom_range(6, 7));
      if ($urandom_range(0, 9) < 7) begin
         ga = region[$urandom_range(0, 7)];
         ga[20:0] = 21'($urandom);
         if ($urandom_range(0, 1)) ga[29:21] = 9'($urandom_range(0, 3));
      end else begin
         ga = {16'($urandom), 32'($urandom)};
      end
      if ($urandom_range(0, 3) == 0) hf = last_frame + 40'($urandom_range(0, 600));
      else hf = {8'($urandom), 32'($urandom)};
      last_frame = hf;
      case ($urandom_range(0, 3))
         0: begin
            rs = '0;
            re = '1;
         end
         1: begin
            rs = {20'($urandom), 32'($urandom)};
            re = {20'($urandom), 32'($urandom)};
         end
         default: begin
            rs = {last_frame, 12'd0} - 52'($urandom_range(0, 1 << 22));
            re = rs + 52'($urandom_range(0, 1 << 23));
         end
      endcase
      send_cmd(cmd, ga, hf, 3'($urandom), 1'($urandom), 1'($urandom), rs, re, gap);
   endtask

   // stimulus
   initial begin
      logic [39:0] base_set [PHASES];
      logic [51:0] mask_set [PHASES];
      int          gap_max;
      reset = 1'b1;
      start = 1'b0;
      req_cmd = '0;
      req_guest_addr = '0;
      req_host_frame = '0;
      req_mem_type = '0;
      req_read_only = 1'b0;
      req_is_write = 1'b0;
      req_range_start = '0;
      req_range_end = '0;
      csr_valid = 1'b0;
      csr_index = 1'b0;
      csr_wdata = '0;
      last_frame = '0;
      foreach (region[i]) region[i] = {16'($urandom), 32'($urandom)};
      base_set = '{40'h0, 40'h100, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFC0,
                   {8'($urandom), 32'($urandom)}, 40'h0};
      mask_set = '{ADDR_MASK_RESET, '1, '0, {20'($urandom), 32'($urandom)},
                   ADDR_MASK_RESET, ADDR_MASK_RESET};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: field extremes, each command and the corner cases
      send_cmd(CMD_PROBE, '0, '0, '0, 1'b0, 1'b0, '0, '0, 0);
      send_cmd(CMD_MAP4K, '0, '0, '0, 1'b0, 1'b0, '0, '0, 0);
      send_cmd(CMD_MAP4K, '1, '1, 3'd7, 1'b1, 1'b0, '0, '0, 0);
      send_cmd(CMD_MAP4K, '1, '1, 3'd7, 1'b1, 1'b1, '0, '0, 0);   // write to read-only
      send_cmd(CMD_MAP2M, '0, '1, 3'd5, 1'b1, 1'b1, '0, '0, 0);   // 4K leaf in the way
      send_cmd(CMD_MAP2M, 48'h0000_4020_0000, '1, 3'd6, 1'b0, 1'b0, '0, '0, 0);
      send_cmd(CMD_PROBE, 48'h0000_4020_1000, '0, '0, 1'b0, 1'b0, '0, '0, 0);
      send_cmd(CMD_PROBE, '1, '0, '0, 1'b0, 1'b0, '0, '0, 0);
      send_cmd(CMD_SEARCH, '0, '0, '0, 1'b0, 1'b0, '0, '1, 0);
      send_cmd(CMD_SEARCH, '0, '0, '0, 1'b0, 1'b0, '1, '0, 0);
      send_cmd(CMD_CLEAR_OVL, '0, '0, '0, 1'b0, 1'b0, '0, 52'hFFF, 0);
      send_cmd(CMD_SEARCH, '0, '0, '0, 1'b0, 1'b0, '0, '1, 0);
      send_cmd(3'd6, '1, '1, 3'd7, 1'b1, 1'b1, '1, '1, 0);
      send_cmd(3'd7, '1, '1, 3'd7, 1'b1, 1'b1, '1, '1, 0);
      send_cmd(CMD_CLEAR_ALL, '0, '0, '0, 1'b0, 1'b0, '0, '0, 0);
      send_cmd(CMD_MAP4K, 48'h8000_0000_0000, 40'h55_5555_5555, 3'd2, 1'b0, 1'b1, '0, '0, 0);
      send_cmd(CMD_PROBE, 48'h8000_0020_0000, '0, '0, 1'b0, 1'b0, '0, '0, 0);
      send_cmd(CMD_CLEAR_OVL, '0, '0, '0, 1'b0, 1'b0, '0, '1, 0);
      send_cmd(CMD_CLEAR_OVL, '0, '0, '0, 1'b0, 1'b0, '1, '1, 0);

      // random phases, each starting from an empty table set
      for (int p = 0; p < PHASES; p++) begin
         send_cmd(CMD_CLEAR_ALL, '0, '0, '0, 1'b0, 1'b0, '0, '0, 0);
         drain();
         csr_write(CSR_POOL_BASE, {12'd0, base_set[p]});
         csr_write(CSR_ADDR_MASK, mask_set[p]);
         gap_max = 14;
         for (int n = 0; n < PHASE_CMDS; n++) begin
            if (n % 40 == 0) gap_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
            if (n == PHASE_CMDS / 2) drain();
            send_random($urandom_range(0, gap_max));
         end
      end

      drain();
      repeat (40) @(negedge clock);
      $display("Ran %0d commands over %0d pool base / mask settings", cmd_count, PHASES + 1);
      $display("Root clears seen: %0d, response errors: %0d", clear_count, errors);
      if (errors == 0 && outstanding == 0)
         $display("[nested_page_table_builder] OK");
      else
         $display("[nested_page_table_builder] ERROR");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/npt_pkg.sv
rtl/core/npt_ram.sv
rtl/core/nested_page_table_builder.sv
verif/nested_page_table_builder_checker.sv
verif/nested_page_table_builder_tb.sv
